// ----- rtl/stepper_reply_frame_parser_core_defines.svh -----
// ---------------------------------------------------------------------------
// Stepper reply frame parser assertion macros
// Shared concurrent assertion forms clocked on clock, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef STEPPER_REPLY_FRAME_PARSER_CORE_DEFINES_SVH
`define STEPPER_REPLY_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define SRFP_ASSERT_NOW(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define SRFP_ASSERT_NEXT(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- rtl/srfp_pkg.sv -----
// ---------------------------------------------------------------------------
// Stepper reply frame parser package
// Frame codes, lengths and result layout shared by the parser.
// ---------------------------------------------------------------------------
package srfp_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] kind_type;
   typedef logic [3:0] count_type;

   localparam byte_type TAIL_BYTE   = 8'h6B;
   localparam byte_type FN_POSITION = 8'h36;
   localparam byte_type FN_SPEED    = 8'h35;
   localparam byte_type FN_HOME     = 8'h3B;
   localparam byte_type ADDR_RESET  = 8'h01;

   localparam count_type LEN_POSITION = 4'd8;
   localparam count_type LEN_SPEED    = 4'd6;
   localparam count_type LEN_OTHER    = 4'd4;
   localparam count_type STORE_DEPTH  = 4'd8;

   localparam kind_type KIND_POSITION = 2'd0;
   localparam kind_type KIND_SPEED    = 2'd1;
   localparam kind_type KIND_HOMING   = 2'd2;
   localparam kind_type KIND_STATUS   = 2'd3;

   localparam int RSP_FIELD_BITS = 77;
   localparam int RSP_DATA_BITS  = 80;

endpackage

// ----- rtl/stepper_reply_frame_parser_core.sv -----
// ---------------------------------------------------------------------------
// Stepper reply frame parser core
// Hunts reply frames in a byte stream and emits one feedback snapshot per
// accepted frame.
// ---------------------------------------------------------------------------
// One request byte can be taken every clock cycle while no held snapshot
// stalls intake. Each byte is captured in an input register, decoded
// against the frame state and, when it closes a frame with the 0x6B tail,
// the updated feedback snapshot is loaded into the result register, from
// which the response is offered. A snapshot held with rsp_tready low keeps
// the next byte in the input register and stalls further intake until the
// snapshot is taken. The device address written on the csr channel is used
// from the next address hunt on.

`include "stepper_reply_frame_parser_core_defines.svh"

module stepper_reply_frame_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,    // device_address
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // reply_kind[1:0], function_code[9:2], position[41:10], position_ok[42],
   // speed[58:43], speed_ok[59], homing_state[67:60], homing_ok[68],
   // command_status[76:69], zero fill[79:77]
   output logic [79:0] rsp_tdata
);

   srfp_pkg::byte_type  dev_addr_ff;
   logic                in_valid_ff;
   logic                in_valid_in;
   srfp_pkg::byte_type  in_byte_ff;
   srfp_pkg::byte_type  store_ff [srfp_pkg::STORE_DEPTH];
   logic                store_wr;
   logic [2:0]          store_idx;
   srfp_pkg::count_type bytes_held_ff, bytes_held_in;
   srfp_pkg::count_type frame_length_ff, frame_length_in;
   srfp_pkg::count_type held_next;
   logic signed [31:0]  position_ff, position_in;
   logic signed [15:0]  speed_ff, speed_in;
   srfp_pkg::byte_type  homing_ff, homing_in;
   srfp_pkg::byte_type  status_ff, status_in;
   logic [2:0]          valid_flags_ff, valid_flags_in;
   srfp_pkg::kind_type  kind;
   logic                emit;
   logic                advance;
   logic                neg;
   logic [31:0]         pos_mag;
   logic [15:0]         spd_mag;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [srfp_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [srfp_pkg::RSP_DATA_BITS-1:0] rsp_data_in;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tvalid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign neg     = store_ff[2] != 8'h00;
   assign pos_mag = {store_ff[3], store_ff[4], store_ff[5], store_ff[6]};
   assign spd_mag = {store_ff[3], store_ff[4]};
   assign held_next = bytes_held_ff + 4'd1;

   always_comb begin
      bytes_held_in   = bytes_held_ff;
      frame_length_in = frame_length_ff;
      position_in     = position_ff;
      speed_in        = speed_ff;
      homing_in       = homing_ff;
      status_in       = status_ff;
      valid_flags_in  = valid_flags_ff;
      store_wr        = 1'b0;
      store_idx       = bytes_held_ff[2:0];
      emit            = 1'b0;
      kind            = srfp_pkg::KIND_STATUS;
      if (advance) begin
         if (bytes_held_ff == 4'd0) begin
            if (in_byte_ff == dev_addr_ff) begin
               store_wr      = 1'b1;
               bytes_held_in = 4'd1;
            end
         end else if (bytes_held_ff == 4'd1) begin
            store_wr      = 1'b1;
            bytes_held_in = 4'd2;
            if (in_byte_ff == srfp_pkg::FN_POSITION) begin
               frame_length_in = srfp_pkg::LEN_POSITION;
            end else if (in_byte_ff == srfp_pkg::FN_SPEED) begin
               frame_length_in = srfp_pkg::LEN_SPEED;
            end else begin
               frame_length_in = srfp_pkg::LEN_OTHER;
            end
         end else if (bytes_held_ff < srfp_pkg::STORE_DEPTH) begin
            store_wr      = 1'b1;
            bytes_held_in = held_next;
            if (held_next == frame_length_ff) begin
               bytes_held_in   = 4'd0;
               frame_length_in = 4'd0;
               if (in_byte_ff == srfp_pkg::TAIL_BYTE) begin
                  emit = 1'b1;
                  if (store_ff[1] == srfp_pkg::FN_POSITION) begin
                     kind = srfp_pkg::KIND_POSITION;
                     if (!neg) begin
                        position_in = pos_mag[31] ? 32'sh7FFF_FFFF : $signed(pos_mag);
                     end else begin
                        position_in = pos_mag[31] ? 32'sh8000_0000 : $signed(32'd0 - pos_mag);
                     end
                     valid_flags_in[0] = 1'b1;
                  end else if (store_ff[1] == srfp_pkg::FN_SPEED) begin
                     kind = srfp_pkg::KIND_SPEED;
                     if (!neg) begin
                        speed_in = spd_mag[15] ? 16'sh7FFF : $signed(spd_mag);
                     end else begin
                        speed_in = spd_mag[15] ? 16'sh8000 : $signed(16'd0 - spd_mag);
                     end
                     valid_flags_in[1] = 1'b1;
                  end else if (store_ff[1] == srfp_pkg::FN_HOME) begin
                     kind = srfp_pkg::KIND_HOMING;
                     homing_in = store_ff[2];
                     valid_flags_in[2] = 1'b1;
                  end else begin
                     kind = srfp_pkg::KIND_STATUS;
                     status_in = store_ff[2];
                  end
               end
            end
         end else begin
            bytes_held_in   = 4'd0;
            frame_length_in = 4'd0;
         end
      end
   end

   assign rsp_data_in = {
      {(srfp_pkg::RSP_DATA_BITS - srfp_pkg::RSP_FIELD_BITS){1'b0}},
      status_in, valid_flags_in[2], homing_in, valid_flags_in[1], speed_in,
      valid_flags_in[0], position_in, store_ff[1], kind};

   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff     <= srfp_pkg::ADDR_RESET;
         in_valid_ff     <= 1'b0;
         bytes_held_ff   <= 4'd0;
         frame_length_ff <= 4'd0;
         position_ff     <= '0;
         speed_ff        <= '0;
         homing_ff       <= '0;
         status_ff       <= '0;
         valid_flags_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            dev_addr_ff <= csr_data;
         end
         in_valid_ff     <= in_valid_in;
         bytes_held_ff   <= bytes_held_in;
         frame_length_ff <= frame_length_in;
         position_ff     <= position_in;
         speed_ff        <= speed_in;
         homing_ff       <= homing_in;
         status_ff       <= status_in;
         valid_flags_ff  <= valid_flags_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (store_wr) begin
         store_ff[store_idx] <= in_byte_ff;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SRFP_ASSERT_NOW(a_held_range, 1'b1, bytes_held_ff <= srfp_pkg::STORE_DEPTH, "held overflow")
   `SRFP_ASSERT_NOW(a_len_idle, bytes_held_ff < 4'd2, frame_length_ff == 4'd0, "early length")
   `SRFP_ASSERT_NEXT(a_sticky, 1'b1, &(valid_flags_ff | ~$past(valid_flags_ff)), "flag lost")
   `SRFP_ASSERT_NEXT(a_pos_ok, emit && kind == srfp_pkg::KIND_POSITION, rsp_data_ff[42], "no pos flag")

endmodule
